// ===== rtl/core/text_stream_line_formatter_macros.svh =====
// Assertion macros shared by the line formatter RTL.
`ifndef TEXT_STREAM_LINE_FORMATTER_MACROS_SVH
`define TEXT_STREAM_LINE_FORMATTER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define TSLF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define TSLF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TSLF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TSLF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/tslf_pkg.sv =====
// Package: constants and helpers for the text stream line formatter.
`timescale 1ns / 1ps

package tslf_pkg;

    localparam int NUMBER_DIGITS = 6;
    localparam int COUNT_W       = 4 * NUMBER_DIGITS;
    // digits, tab, then at most two bytes for the character itself
    localparam int MAX_RESULTS   = NUMBER_DIGITS + 3;
    localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W         = $clog2(MAX_RESULTS);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUMBER_MODE      = 3'd0,
        REG_SQUEEZE_BLANK    = 3'd1,
        REG_SHOW_ENDS        = 3'd2,
        REG_SHOW_TABS        = 3'd3,
        REG_SHOW_NONPRINTING = 3'd4
    } cfg_reg_t;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CTRL_TOP  = 8'h20;
    localparam logic [7:0] CARET_OFS = 8'h40;

    typedef logic [COUNT_W-1:0] bcd_count_t;

    // BCD increment with saturation at all nines.
    function automatic bcd_count_t bcd_bump(input bcd_count_t v);
        bcd_count_t r;
        logic       carry;
        logic       all_nine;
        logic [3:0] d;
        r        = v;
        carry    = 1'b1;
        all_nine = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            d = v[4*i +: 4];
            if (d != 4'd9) begin
                all_nine = 1'b0;
            end
            if (carry) begin
                if (d >= 4'd9) begin
                    r[4*i +: 4] = 4'd0;
                end else begin
                    r[4*i +: 4] = d + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        return all_nine ? v : r;
    endfunction

endpackage

// ===== rtl/core/text_stream_line_formatter.sv =====
// Top level: cat-style line formatter, one text byte in, a burst of bytes out.
`timescale 1ns / 1ps
//
//  Channel | Ports                          | Payload
//  --------+--------------------------------+----------------------------------
//  input   | s_tvalid s_tready s_tdata      | data_byte [7:0]
//  output  | m_tvalid m_tready m_tdata      | out_byte [7:0], m_tlast = last
//          | m_tlast                        |
//  config  | cfg_wr_en cfg_index cfg_wdata  | register index, value
//
//  An input byte is decoded in the cycle it is accepted: the line state
//  updates and its burst (0 to 9 bytes) is loaded into the output buffer.
//  The buffer then drains one byte per cycle while m_tready is high; the next
//  request is taken in the cycle the previous burst's last byte leaves.
//  A squeezed newline makes no output.
//  aresetn is synchronous, active low; it clears options and count and empties the buffer.
`include "text_stream_line_formatter_macros.svh"

module text_stream_line_formatter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] out_byte
    output logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [tslf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tslf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // options
    logic [1:0] number_mode_reg;
    logic       squeeze_reg;
    logic       show_ends_reg;
    logic       show_tabs_reg;
    logic       show_np_reg;

    // line state
    tslf_pkg::bcd_count_t count_reg, count_next;
    logic at_start_reg,  at_start_next;
    logic blank_reg,     blank_next;
    logic prev_nl_reg,   prev_nl_next;

    // output buffer
    logic [7:0]                     buf_reg  [tslf_pkg::MAX_RESULTS];
    logic [7:0]                     buf_next [tslf_pkg::MAX_RESULTS];
    logic [tslf_pkg::RES_CNT_W-1:0] cnt_reg, cnt_next;
    logic [tslf_pkg::IDX_W-1:0]     idx_reg;
    logic                           busy_reg;

    logic       in_acc;
    logic       burst_done;
    logic       is_nl;
    logic       do_num;
    logic       tab_shown;
    logic       is_ctrl;
    logic       blank_kept;
    logic       keep;
    logic [7:0] t0, t1;
    logic [1:0] tail_cnt;
    logic [7:0] digit_byte [tslf_pkg::NUMBER_DIGITS];
    logic       leading;
    logic [3:0] dig;

    assign m_tvalid   = busy_reg;
    assign m_tdata    = buf_reg[idx_reg];
    assign m_tlast    = (tslf_pkg::RES_CNT_W'(idx_reg) + tslf_pkg::RES_CNT_W'(1)) == cnt_reg;
    assign burst_done = busy_reg && m_tready && m_tlast;
    assign s_tready   = !busy_reg || burst_done;
    assign in_acc     = s_tvalid && s_tready;

    // decode of one input byte
    always_comb begin
        is_nl     = (s_tdata == tslf_pkg::CH_LF);
        do_num    = (number_mode_reg != 2'd0) && at_start_reg
                    && !(number_mode_reg[1] && is_nl)
                    && !(squeeze_reg && blank_reg && is_nl);
        count_next = do_num ? tslf_pkg::bcd_bump(count_reg) : count_reg;
        tab_shown = (s_tdata == tslf_pkg::CH_TAB) && show_tabs_reg;
        is_ctrl   = show_np_reg
                    && ((s_tdata < tslf_pkg::CTRL_TOP) || (s_tdata == tslf_pkg::CH_DEL))
                    && !is_nl && (s_tdata != tslf_pkg::CH_TAB);
        // a non-newline byte ends a blank run, except a tab shown as ^I
        blank_kept = blank_reg && is_nl;
        keep       = !(blank_kept && squeeze_reg);

        at_start_next = do_num ? 1'b0 : at_start_reg;
        blank_next    = blank_reg;
        prev_nl_next  = prev_nl_reg;
        t0       = s_tdata;
        t1       = s_tdata;
        tail_cnt = 2'd0;

        if (tab_shown) begin
            t0       = tslf_pkg::CH_CARET;
            t1       = tslf_pkg::CH_I;
            tail_cnt = 2'd2;
        end else begin
            if (is_ctrl) begin
                t0       = tslf_pkg::CH_CARET;
                t1       = (s_tdata == tslf_pkg::CH_DEL) ? tslf_pkg::CH_QMARK
                                                         : s_tdata + tslf_pkg::CARET_OFS;
                tail_cnt = 2'd2;
            end else if (keep) begin
                if (show_ends_reg && is_nl) begin
                    t0       = tslf_pkg::CH_DOLLAR;
                    t1       = s_tdata;
                    tail_cnt = 2'd2;
                end else begin
                    t0       = s_tdata;
                    tail_cnt = 2'd1;
                end
            end
            blank_next    = blank_kept || (is_nl && prev_nl_reg);
            prev_nl_next  = is_nl;
            at_start_next = is_nl;
        end

        // right-aligned number with leading blanks
        leading = 1'b1;
        dig     = 4'd0;
        for (int i = tslf_pkg::NUMBER_DIGITS - 1; i >= 0; i--) begin
            dig = count_next[4*i +: 4];
            if (dig != 4'd0 || i == 0) begin
                leading = 1'b0;
            end
            digit_byte[tslf_pkg::NUMBER_DIGITS - 1 - i] =
                leading ? tslf_pkg::CH_SPACE : (tslf_pkg::CH_ZERO | {4'd0, dig});
        end

        for (int j = 0; j < tslf_pkg::MAX_RESULTS; j++) begin
            buf_next[j] = 8'd0;
        end
        if (do_num) begin
            for (int j = 0; j < tslf_pkg::NUMBER_DIGITS; j++) begin
                buf_next[j] = digit_byte[j];
            end
            buf_next[tslf_pkg::NUMBER_DIGITS]     = tslf_pkg::CH_TAB;
            buf_next[tslf_pkg::NUMBER_DIGITS + 1] = t0;
            buf_next[tslf_pkg::NUMBER_DIGITS + 2] = t1;
            cnt_next = tslf_pkg::RES_CNT_W'(tslf_pkg::NUMBER_DIGITS + 1)
                       + tslf_pkg::RES_CNT_W'(tail_cnt);
        end else begin
            buf_next[0] = t0;
            buf_next[1] = t1;
            cnt_next    = tslf_pkg::RES_CNT_W'(tail_cnt);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            number_mode_reg <= 2'd0;
            squeeze_reg     <= 1'b0;
            show_ends_reg   <= 1'b0;
            show_tabs_reg   <= 1'b0;
            show_np_reg     <= 1'b0;
            count_reg       <= '0;
            at_start_reg    <= 1'b1;
            blank_reg       <= 1'b0;
            prev_nl_reg     <= 1'b0;
            idx_reg         <= '0;
            busy_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    tslf_pkg::REG_NUMBER_MODE:      number_mode_reg <= cfg_wdata;
                    tslf_pkg::REG_SQUEEZE_BLANK:    squeeze_reg     <= cfg_wdata[0];
                    tslf_pkg::REG_SHOW_ENDS:        show_ends_reg   <= cfg_wdata[0];
                    tslf_pkg::REG_SHOW_TABS:        show_tabs_reg   <= cfg_wdata[0];
                    tslf_pkg::REG_SHOW_NONPRINTING: show_np_reg     <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                count_reg    <= count_next;
                at_start_reg <= at_start_next;
                blank_reg    <= blank_next;
                prev_nl_reg  <= prev_nl_next;
                idx_reg      <= '0;
                busy_reg     <= (cnt_next != '0);
            end else if (busy_reg && m_tready) begin
                if (m_tlast) begin
                    busy_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + tslf_pkg::IDX_W'(1);
                end
            end
        end
    end

    // burst payload, no reset needed
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
        end
    end

    `TSLF_ASSERT_IMPL(a_burst_index_in_range, aclk, aresetn, busy_reg,
        (cnt_reg != '0) && (tslf_pkg::RES_CNT_W'(idx_reg) < cnt_reg),
        "burst index beyond burst length")
    `TSLF_ASSERT_IMPL(a_accept_only_at_burst_end, aclk, aresetn, in_acc && busy_reg,
        m_tready && m_tlast, "request taken while a burst is still pending")
    `TSLF_ASSERT_NEXT(a_count_moves_on_accept, aclk, aresetn, !in_acc,
        $stable(count_reg), "line count changed without an input request")

endmodule
